/* sv/assert_macros.svh */
// assertion macros shared by the mixer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OMW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("omw assertion failed");
`define OMW_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("omw assertion failed");
`else
`define OMW_ASSERT(label, clk, rst_n, prop)
`define OMW_ASSERT_NR(label, clk, prop)
`endif
`endif

/* sv/omw_pkg.sv */
// shared constants, sine table and helper functions of the omni wheel mixer
// no dependencies; imported by every mixer module
`default_nettype none
package omw_pkg;

    localparam int MOTOR_COUNT        = 4;
    localparam int SINE_FRAC_BITS_DEF = 15;
    localparam int CFG_ADDR_W         = 3;
    localparam int ANGLE_W            = 9;

    localparam logic [8:0] FULL_TURN    = 9'd360;
    localparam logic [8:0] HALF_TURN    = 9'd180;
    localparam logic [7:0] QUARTER_TURN = 8'd90;
    localparam logic [7:0] PWM_LIMIT    = 8'd255;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ANGLE_0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ANGLE_1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ANGLE_2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_ANGLE_3 = 3'd3;

    // battery scale reciprocal: x / 100 == (x * 20972) >> 21 for x below 2^15
    localparam logic [14:0] BATT_RECIP = 15'd20972;
    localparam int          BATT_SHIFT = 21;

    // per-transaction sign and limit flags carried down the pipe
    typedef struct packed {
        logic                   over;
        logic [MOTOR_COUNT-1:0] fwd;
        logic [MOTOR_COUNT-1:0] rev;
    } omw_flags_t;

    // round(sin(d deg) * 65536), d = 0..90
    localparam logic [16:0] QUARTER_SINE [0:90] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
        17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
        17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
        17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
        17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
        17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
        17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
        17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
        17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
        17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
        17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // reduce a 9-bit angle into 0..359
    function automatic logic [8:0] mod_turn9(input logic [8:0] a);
        return (a >= FULL_TURN) ? a - FULL_TURN : a;
    endfunction

    // clamp battery to 0..100 and form the unsigned q1.8 scale
    function automatic logic [8:0] batt_scale(input logic signed [8:0] batt);
        logic [6:0]  b;
        logic [14:0] x;
        logic [29:0] p;
        if (batt <= 9'sd0) begin
            b = 7'd0;
        end else if (batt > 9'sd100) begin
            b = 7'd100;
        end else begin
            b = batt[6:0];
        end
        x = {b, 8'd0} + 15'd50;
        p = 30'(x) * 30'(BATT_RECIP);
        return p[BATT_SHIFT +: 9];
    endfunction

endpackage
`default_nettype wire

/* sv/omw_front.sv */
// front stages: direction select, battery scale, per-motor angle and sine lookup
// depends on omw_pkg
`default_nettype none
module omw_front #(
    parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF,
    localparam int SIN_W = SINE_FRAC_BITS + 2
) (
    input  logic                                       aclk,
    input  logic [1:0]                                 stage_en,
    input  logic signed [9:0]                          speed_in,
    input  logic [8:0]                                 move_angle_in,
    input  logic signed [8:0]                          rotation_in,
    input  logic signed [8:0]                          battery_in,
    input  logic signed [9:0]                          line_in,
    input  logic signed [8:0]                          goal_in,
    input  logic [omw_pkg::MOTOR_COUNT-1:0][8:0]       motor_angle,
    output logic signed [omw_pkg::MOTOR_COUNT-1:0][SIN_W-1:0] sine_out,
    output logic signed [9:0]                          speed_out,
    output logic signed [9:0]                          cg_out,
    output logic [8:0]                                 scale_out
);
    import omw_pkg::*;

    logic signed [9:0]  speed_reg, cg_reg, speed2_reg, cg2_reg;
    logic [8:0]         scale_reg, scale2_reg, dir_reg;
    logic [8:0]         dir_next;
    logic signed [10:0] line_wrap;
    logic signed [MOTOR_COUNT-1:0][SIN_W-1:0] sine_reg, sine_next;

    // travel direction in 0..359
    always_comb begin
        line_wrap = 11'(line_in) + 11'sd360;
        if (line_wrap < 0) begin
            line_wrap = line_wrap + 11'sd360;
        end
        if (line_in == -10'sd1) begin
            dir_next = mod_turn9(move_angle_in);
        end else if (line_in < 0) begin
            dir_next = line_wrap[8:0];
        end else begin
            dir_next = mod_turn9(line_in[8:0]);
        end
    end

    // stage 0: command register
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            speed_reg <= speed_in;
            cg_reg    <= 10'(rotation_in) + 10'(goal_in);
            scale_reg <= batt_scale(battery_in);
            dir_reg   <= dir_next;
        end
    end

    // per-motor angle difference, quadrant fold and sine lookup
    always_comb begin
        logic [9:0]  diff_w;
        logic [8:0]  diff;
        logic [7:0]  half;
        logic [6:0]  idx;
        logic        neg;
        logic [33:0] scaled;
        logic signed [SIN_W-1:0] mag;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            diff_w = {1'b0, mod_turn9(motor_angle[m])} + {1'b0, FULL_TURN} - {1'b0, dir_reg};
            diff   = (diff_w >= {1'b0, FULL_TURN}) ? 9'(diff_w - {1'b0, FULL_TURN})
                                                   : diff_w[8:0];
            neg    = (diff >= HALF_TURN);
            half   = neg ? 8'(diff - HALF_TURN) : diff[7:0];
            idx    = (half > QUARTER_TURN) ? 7'(8'(HALF_TURN) - half) : half[6:0];
            scaled = (34'(QUARTER_SINE[idx]) << SINE_FRAC_BITS) + 34'd32768;
            mag    = scaled[16 +: SIN_W];
            sine_next[m] = neg ? -mag : mag;
        end
    end

    // stage 1: sine register
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            sine_reg   <= sine_next;
            speed2_reg <= speed_reg;
            cg2_reg    <= cg_reg;
            scale2_reg <= scale_reg;
        end
    end

    assign sine_out  = sine_reg;
    assign speed_out = speed2_reg;
    assign cg_out    = cg2_reg;
    assign scale_out = scale2_reg;

endmodule
`default_nettype wire

/* sv/omw_mix.sv */
// mixing stages: speed product, battery scale, magnitude and largest search
// depends on omw_pkg
`default_nettype none
module omw_mix #(
    parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF,
    localparam int SIN_W  = SINE_FRAC_BITS + 2,
    localparam int BASE_W = SINE_FRAC_BITS + 12,
    localparam int VAL_W  = SINE_FRAC_BITS + 22,
    localparam int MAG_W  = SINE_FRAC_BITS + 21,
    localparam int NUM_W  = MAG_W + 8
) (
    input  logic                                       aclk,
    input  logic [3:0]                                 stage_en,
    input  logic signed [omw_pkg::MOTOR_COUNT-1:0][SIN_W-1:0] sine_in,
    input  logic signed [9:0]                          speed_in,
    input  logic signed [9:0]                          cg_in,
    input  logic [8:0]                                 scale_in,
    output logic [omw_pkg::MOTOR_COUNT-1:0][NUM_W-1:0] rem_out,
    output logic [MAG_W-1:0]                           dvs_out,
    output logic [omw_pkg::MOTOR_COUNT-1:0][7:0]       q_out,
    output omw_pkg::omw_flags_t                        flags_out
);
    import omw_pkg::*;

    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(PWM_LIMIT) << (SINE_FRAC_BITS + 8);

    logic signed [MOTOR_COUNT-1:0][BASE_W-1:0] base_reg;
    logic [8:0]                                scale_reg;
    logic signed [MOTOR_COUNT-1:0][VAL_W-1:0]  val_reg;
    logic [MOTOR_COUNT-1:0][MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]                          max01_reg, max23_reg;
    logic [MOTOR_COUNT-1:0]                    fwd_reg, rev_reg;
    logic [MOTOR_COUNT-1:0][NUM_W-1:0]         rem_reg;
    logic [MAG_W-1:0]                          dvs_reg;
    logic [MOTOR_COUNT-1:0][7:0]               q_reg;
    omw_flags_t                                flags_reg;

    // stage 2: sine times speed plus the rotation and goal terms
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                base_reg[m] <= BASE_W'($signed(sine_in[m])) * BASE_W'(speed_in)
                             + (BASE_W'(cg_in) <<< SINE_FRAC_BITS);
            end
            scale_reg <= scale_in;
        end
    end

    // stage 3: battery scaling
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                val_reg[m] <= VAL_W'($signed(base_reg[m]))
                            * VAL_W'($signed({1'b0, scale_reg}));
            end
        end
    end

    // stage 4: magnitude, sign bits and pairwise maximum
    always_ff @(posedge aclk) begin
        logic [MOTOR_COUNT-1:0][MAG_W-1:0] mag;
        if (stage_en[2]) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                mag[m]     = val_reg[m][VAL_W-1] ? MAG_W'(-val_reg[m]) : MAG_W'(val_reg[m]);
                mag_reg[m] <= mag[m];
                fwd_reg[m] <= ($signed(val_reg[m]) > 0);
                rev_reg[m] <= val_reg[m][VAL_W-1];
            end
            max01_reg <= (mag[0] > mag[1]) ? mag[0] : mag[1];
            max23_reg <= (mag[2] > mag[3]) ? mag[2] : mag[3];
        end
    end

    // stage 5: largest magnitude, limit test and divider setup
    always_ff @(posedge aclk) begin
        logic [MAG_W-1:0] largest;
        logic [MAG_W-1:0] hi;
        logic             over;
        if (stage_en[3]) begin
            largest = (max01_reg > max23_reg) ? max01_reg : max23_reg;
            over    = (largest > LIMIT);
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                hi         = mag_reg[m] >> (SINE_FRAC_BITS + 8);
                rem_reg[m] <= (NUM_W'(mag_reg[m]) << 8) - NUM_W'(mag_reg[m]);
                if (over) begin
                    q_reg[m] <= 8'd0;
                end else if (hi > MAG_W'(PWM_LIMIT)) begin
                    q_reg[m] <= PWM_LIMIT;
                end else begin
                    q_reg[m] <= hi[7:0];
                end
            end
            dvs_reg        <= largest;
            flags_reg.over <= over;
            flags_reg.fwd  <= fwd_reg;
            flags_reg.rev  <= rev_reg;
        end
    end

    assign rem_out   = rem_reg;
    assign dvs_out   = dvs_reg;
    assign q_out     = q_reg;
    assign flags_out = flags_reg;

endmodule
`default_nettype wire

/* sv/omw_div_stage.sv */
// one quotient bit of the pipelined restoring divider for all four motors
// depends on omw_pkg
`default_nettype none
module omw_div_stage #(
    parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF,
    parameter int BIT_POS = 7,
    localparam int MAG_W = SINE_FRAC_BITS + 21,
    localparam int NUM_W = MAG_W + 8
) (
    input  logic                                       aclk,
    input  logic                                       stage_en,
    input  logic [omw_pkg::MOTOR_COUNT-1:0][NUM_W-1:0] rem_in,
    input  logic [MAG_W-1:0]                           dvs_in,
    input  logic [omw_pkg::MOTOR_COUNT-1:0][7:0]       q_in,
    input  omw_pkg::omw_flags_t                        flags_in,
    output logic [omw_pkg::MOTOR_COUNT-1:0][NUM_W-1:0] rem_out,
    output logic [MAG_W-1:0]                           dvs_out,
    output logic [omw_pkg::MOTOR_COUNT-1:0][7:0]       q_out,
    output omw_pkg::omw_flags_t                        flags_out
);
    import omw_pkg::*;

    logic [MOTOR_COUNT-1:0][NUM_W-1:0] rem_reg;
    logic [MAG_W-1:0]                  dvs_reg;
    logic [MOTOR_COUNT-1:0][7:0]       q_reg;
    omw_flags_t                        flags_reg;

    // trial subtract of the shifted divisor, only when the limit applies
    always_ff @(posedge aclk) begin
        logic [NUM_W-1:0] sub;
        if (stage_en) begin
            sub = NUM_W'(dvs_in) << BIT_POS;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                if (flags_in.over && rem_in[m] >= sub) begin
                    rem_reg[m] <= rem_in[m] - sub;
                    q_reg[m]   <= q_in[m] | (8'd1 << BIT_POS);
                end else begin
                    rem_reg[m] <= rem_in[m];
                    q_reg[m]   <= q_in[m];
                end
            end
            dvs_reg   <= dvs_in;
            flags_reg <= flags_in;
        end
    end

    assign rem_out   = rem_reg;
    assign dvs_out   = dvs_reg;
    assign q_out     = q_reg;
    assign flags_out = flags_reg;

endmodule
`default_nettype wire

/* sv/omni_wheel_speed_mixer_core.sv */
// an input transaction reaches the result through the 6 mixing stages plus 8 one-bit
// divider stages; throughput one transaction per cycle unless the pipe stalls; a stage
// holds only while m_tready is low and it and every later stage are full; a command with
// move_enable low is consumed and yields no result. synchronous active-low reset clears
// stage valid bits and restores motor angles to 45, 135, 225 and 315 degrees
`default_nettype none
`include "assert_macros.svh"
module omni_wheel_speed_mixer_core #(
    parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // speed[9:0] move_angle[18:10] rotation_correction[27:19]
    // battery_level[36:28] line_direction[46:37] goal_offset[55:47]
    input  logic [55:0]                       s_tdata,
    // move_enable[0]
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // per motor m at 10*m: pwm_m[7:0] fwd_m[8] rev_m[9]
    output logic [39:0]                       m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [omw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [omw_pkg::ANGLE_W-1:0]       cfg_wdata
);
    import omw_pkg::*;

    localparam int SIN_W    = SINE_FRAC_BITS + 2;
    localparam int MAG_W    = SINE_FRAC_BITS + 21;
    localparam int NUM_W    = MAG_W + 8;
    localparam int DIV_BITS = 8;
    localparam int STAGES   = 6 + DIV_BITS;

    logic [MOTOR_COUNT-1:0][8:0] angle_reg;
    logic [STAGES-1:0]           valid_reg;
    logic [STAGES-1:0]           ready;

    logic signed [MOTOR_COUNT-1:0][SIN_W-1:0] sine;
    logic signed [9:0] speed_f, cg_f;
    logic [8:0]        scale_f;

    logic [DIV_BITS:0][MOTOR_COUNT-1:0][NUM_W-1:0] rem_p;
    logic [DIV_BITS:0][MAG_W-1:0]                  dvs_p;
    logic [DIV_BITS:0][MOTOR_COUNT-1:0][7:0]       q_p;
    omw_flags_t [DIV_BITS:0]                       flags_p;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg[0] <= 9'd45;
            angle_reg[1] <= 9'd135;
            angle_reg[2] <= 9'd225;
            angle_reg[3] <= 9'd315;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MOTOR_ANGLE_0: angle_reg[0] <= cfg_wdata;
                REG_MOTOR_ANGLE_1: angle_reg[1] <= cfg_wdata;
                REG_MOTOR_ANGLE_2: angle_reg[2] <= cfg_wdata;
                REG_MOTOR_ANGLE_3: angle_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage moves when it or any later stage has a hole, or the sink takes
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            ready[i] = m_tready || (((~valid_reg) >> i) != '0);
        end
    end

    // valid bits travel alongside the data registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_tvalid && s_tuser[0];
            end
            for (int i = 1; i < STAGES; i++) begin
                if (ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    omw_front #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_front (
        .aclk          (aclk),
        .stage_en      (ready[1:0]),
        .speed_in      (s_tdata[9:0]),
        .move_angle_in (s_tdata[18:10]),
        .rotation_in   (s_tdata[27:19]),
        .battery_in    (s_tdata[36:28]),
        .line_in       (s_tdata[46:37]),
        .goal_in       (s_tdata[55:47]),
        .motor_angle   (angle_reg),
        .sine_out      (sine),
        .speed_out     (speed_f),
        .cg_out        (cg_f),
        .scale_out     (scale_f)
    );

    omw_mix #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_mix (
        .aclk      (aclk),
        .stage_en  (ready[5:2]),
        .sine_in   (sine),
        .speed_in  (speed_f),
        .cg_in     (cg_f),
        .scale_in  (scale_f),
        .rem_out   (rem_p[0]),
        .dvs_out   (dvs_p[0]),
        .q_out     (q_p[0]),
        .flags_out (flags_p[0])
    );

    // divider stages, quotient msb first
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        omw_div_stage #(
            .SINE_FRAC_BITS (SINE_FRAC_BITS),
            .BIT_POS        (DIV_BITS - 1 - k)
        ) u_div (
            .aclk      (aclk),
            .stage_en  (ready[6+k]),
            .rem_in    (rem_p[k]),
            .dvs_in    (dvs_p[k]),
            .q_in      (q_p[k]),
            .flags_in  (flags_p[k]),
            .rem_out   (rem_p[k+1]),
            .dvs_out   (dvs_p[k+1]),
            .q_out     (q_p[k+1]),
            .flags_out (flags_p[k+1])
        );
    end

    // result packing
    always_comb begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            m_tdata[10*m +: 10] = {flags_p[DIV_BITS].rev[m], flags_p[DIV_BITS].fwd[m],
                                   q_p[DIV_BITS][m]};
        end
    end

    assign m_tvalid = valid_reg[STAGES-1];
    assign s_tready = ready[0];

    `OMW_ASSERT(a_ready_when_sink_free, aclk, aresetn, (!m_tvalid || m_tready) |-> s_tready)
    `OMW_ASSERT(a_disabled_no_result, aclk, aresetn, (s_tvalid && s_tready && !s_tuser[0]) |=> !valid_reg[0])
    `OMW_ASSERT(a_dir_bits_exclusive, aclk, aresetn, m_tvalid |-> ((flags_p[DIV_BITS].fwd & flags_p[DIV_BITS].rev) == '0))

endmodule
`default_nettype wire
